[rtl/core/sbr_pkg.sv]
// Shared types and constants for the supersample box resolve block.
// No dependencies; compile first.
package sbr_pkg;

    localparam int CHAN_W         = 8;
    localparam int CHANNELS       = 4;
    localparam int COORD_W        = 10;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int RATE_CFG_W     = 3;
    localparam int DIM_CFG_W      = 11;
    localparam int RATE_CODE_W    = 3;
    localparam int OUT_DEPTH      = 4;
    localparam int OUT_PTR_W      = 2;
    localparam int OUT_CNT_W      = 3;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RATE   = 4;
    localparam int RESET_RATE     = 1;
    localparam int RESET_WIDTH    = 1024;
    localparam int RESET_HEIGHT   = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SS_RATE      = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic                   done;
        logic [RATE_CODE_W-1:0] rate_m1;
    } pix_meta_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic               done;
    } pixel_t;

endpackage

[rtl/core/sbr_if.sv]
// Valid/ready channel interfaces for sample input and pixel output beats.
// Depends on sbr_pkg.
interface sbr_sample_if;
    import sbr_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] sample_red;
    logic [CHAN_W-1:0] sample_green;
    logic [CHAN_W-1:0] sample_blue;
    logic [CHAN_W-1:0] sample_alpha;

    modport source (output valid, sample_red, sample_green, sample_blue, sample_alpha,
                    input ready);
    modport sink (input valid, sample_red, sample_green, sample_blue, sample_alpha,
                  output ready);
endinterface

interface sbr_pixel_if;
    import sbr_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  pixel_red;
    logic [CHAN_W-1:0]  pixel_green;
    logic [CHAN_W-1:0]  pixel_blue;
    logic [CHAN_W-1:0]  pixel_alpha;
    logic               frame_done;

    modport source (output valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
                    pixel_alpha, frame_done, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
                  pixel_alpha, frame_done, output ready);
endinterface

[rtl/core/sbr_line_store.sv]
// Line store: one entry of packed channel sums per output column.
// Synchronous write, registered read. Depends on sbr_pkg.
module sbr_line_store #(
    parameter int DEPTH  = sbr_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata
);
    import sbr_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/sbr_avg.sv]
// Block average: divide four channel sums by rate squared through a
// reciprocal multiply, saturate to 8 bits. Depends on sbr_pkg.
module sbr_avg #(
    parameter int SUM_W = sbr_pkg::CHAN_W + 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [sbr_pkg::CHANNELS*SUM_W-1:0] in_sums,
    input  sbr_pkg::pix_meta_t                in_meta,
    output logic                              out_valid,
    output sbr_pkg::pixel_t                   out_pixel
);
    import sbr_pkg::*;

    localparam int K    = SUM_W + 6;
    localparam int M_W  = K + 1;
    localparam int P_W  = SUM_W + M_W;
    localparam int Q_W  = P_W - K;

    localparam logic [M_W-1:0] RECIP [8] = '{
        M_W'((2**K) / 1),
        M_W'((2**K + 3) / 4),
        M_W'((2**K + 8) / 9),
        M_W'((2**K + 15) / 16),
        M_W'((2**K + 24) / 25),
        M_W'((2**K + 35) / 36),
        M_W'((2**K + 48) / 49),
        M_W'((2**K + 63) / 64)
    };

    logic                        s2_valid_reg;
    logic [CHANNELS*SUM_W-1:0]   s2_sums_reg;
    pix_meta_t                   s2_meta_reg;
    logic [CHANNELS*CHAN_W-1:0]  avg_bus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s2_sums_reg <= in_sums;
            s2_meta_reg <= in_meta;
        end
    end

    always_comb
    begin
        logic [M_W-1:0] recip;
        logic [P_W-1:0] prod;
        logic [Q_W-1:0] quot;
        recip = RECIP[s2_meta_reg.rate_m1];
        prod  = '0;
        quot  = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            prod = P_W'(s2_sums_reg[c*SUM_W +: SUM_W]) * P_W'(recip);
            quot = prod[P_W-1:K];
            if (quot > Q_W'(255))
            begin
                avg_bus[c*CHAN_W +: CHAN_W] = '1;
            end
            else
            begin
                avg_bus[c*CHAN_W +: CHAN_W] = quot[CHAN_W-1:0];
            end
        end
    end

    assign out_valid       = s2_valid_reg;
    assign out_pixel.x     = s2_meta_reg.x;
    assign out_pixel.y     = s2_meta_reg.y;
    assign out_pixel.done  = s2_meta_reg.done;
    assign out_pixel.red   = avg_bus[0*CHAN_W +: CHAN_W];
    assign out_pixel.green = avg_bus[1*CHAN_W +: CHAN_W];
    assign out_pixel.blue  = avg_bus[2*CHAN_W +: CHAN_W];
    assign out_pixel.alpha = avg_bus[3*CHAN_W +: CHAN_W];

endmodule

[rtl/core/sbr_out_fifo.sv]
// Output queue for finished pixels, driving the pixel channel.
// Reports its fill level for input credit. Depends on sbr_pkg, sbr_if.
module sbr_out_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  sbr_pkg::pixel_t                 push_data,
    output logic [sbr_pkg::OUT_CNT_W-1:0]   count,
    sbr_pixel_if.source                     pixels
);
    import sbr_pkg::*;

    pixel_t                 mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;
    logic                   pop;
    pixel_t                 head;

    assign pop = pixels.valid && pixels.ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + OUT_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head               = mem_reg[rd_ptr_reg];
    assign count              = count_reg;
    assign pixels.valid       = (count_reg != '0);
    assign pixels.pixel_x     = head.x;
    assign pixels.pixel_y     = head.y;
    assign pixels.pixel_red   = head.red;
    assign pixels.pixel_green = head.green;
    assign pixels.pixel_blue  = head.blue;
    assign pixels.pixel_alpha = head.alpha;
    assign pixels.frame_done  = head.done;

endmodule

[rtl/core/supersample_box_resolve_top.sv]
// Supersample box resolve, top level.
// Depends on sbr_pkg, sbr_if, sbr_line_store, sbr_avg, sbr_out_fifo.
//
// Samples enter on the samples channel in row-major order over a frame of
// frame_width*rate by frame_height*rate samples. Each output
// pixel is the truncated average of its rate-by-rate block and leaves on the
// pixels channel with its column, row and a frame_done flag on the frame's
// last pixel. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while no beat is in flight, the block does not enforce it.
// Throughput: one sample per clock unless held off as under Stall below, set by the
// line store read-modify-write (read at accept, update and write back in the next cycle,
// forwarded when consecutive samples hit the same column).
// A block's last accepted sample passes the s1 stage (line store update), the s2
// divide stage and the output queue before its pixel is valid on the pixels channel.
// Stall: a four-beat output queue absorbs pixels; samples that end a block
// are held off while the queue plus pixels in flight already fill it, other
// samples keep flowing.
// Reset: counters return to the frame origin and registers to rate 1,
// 1024 by 1024. The line store is not cleared; every block start overwrites
// its column entry.
module supersample_box_resolve_top #(
    parameter int MAX_WIDTH  = sbr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbr_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RATE   = sbr_pkg::DEF_MAX_RATE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    sbr_sample_if.sink                      samples,
    sbr_pixel_if.source                     pixels
);
    import sbr_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SUB_W  = (MAX_RATE > 1) ? $clog2(MAX_RATE) : 1;
    localparam int RATE_W = $clog2(MAX_RATE + 1);
    localparam int SUM_W  = CHAN_W + $clog2(MAX_RATE * MAX_RATE);
    localparam int SUMS_W = CHANNELS * SUM_W;

    function automatic logic [31:0] clamp_cfg(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        r = v;
        if (v == 32'd0)
        begin
            r = 32'd1;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    logic [RATE_CFG_W-1:0] rate_cfg_reg;
    logic [DIM_CFG_W-1:0]  frame_width_reg;
    logic [DIM_CFG_W-1:0]  frame_height_reg;

    logic [SUB_W-1:0]      sub_col_reg;
    logic [SUB_W-1:0]      sub_col_next;
    logic [COL_W-1:0]      column_index_reg;
    logic [COL_W-1:0]      column_index_next;
    logic [SUB_W-1:0]      sub_row_reg;
    logic [SUB_W-1:0]      sub_row_next;
    logic [ROW_W-1:0]      row_index_reg;
    logic [ROW_W-1:0]      row_index_next;

    logic [RATE_W-1:0]     rate_eff;
    logic [COL_W:0]        width_eff;
    logic [ROW_W:0]        height_eff;
    logic                  last_sub_col;
    logic                  last_sub_row;
    logic                  last_col;
    logic                  last_row;
    logic                  block_first;
    logic                  emit_cur;
    logic                  frame_end;
    logic                  in_fire;
    logic                  in_ready;
    pix_meta_t             meta_cur;
    logic [CHANNELS*CHAN_W-1:0] samp_cur;

    logic                       s1_valid_reg;
    logic                       s1_emit_reg;
    logic [COL_W-1:0]           s1_col_reg;
    logic                       s1_first_reg;
    logic [CHANNELS*CHAN_W-1:0] s1_samp_reg;
    pix_meta_t                  s1_meta_reg;
    logic [SUMS_W-1:0]          s1_new_sums;
    logic [SUMS_W-1:0]          s1_base_sums;
    logic [SUMS_W-1:0]          rd_sums;

    logic                       fwd_valid_reg;
    logic [COL_W-1:0]           fwd_col_reg;
    logic [SUMS_W-1:0]          fwd_sums_reg;

    logic                       avg_valid;
    pixel_t                     avg_pixel;
    logic [OUT_CNT_W-1:0]       fifo_count;
    logic [OUT_CNT_W-1:0]       reserved;

    assign rate_eff   = RATE_W'(clamp_cfg(32'(rate_cfg_reg), 32'(MAX_RATE)));
    assign width_eff  = (COL_W+1)'(clamp_cfg(32'(frame_width_reg), 32'(MAX_WIDTH)));
    assign height_eff = (ROW_W+1)'(clamp_cfg(32'(frame_height_reg), 32'(MAX_HEIGHT)));

    assign last_sub_col = (RATE_W'(sub_col_reg) + RATE_W'(1)) >= rate_eff;
    assign last_sub_row = (RATE_W'(sub_row_reg) + RATE_W'(1)) >= rate_eff;
    assign last_col     = ((COL_W+1)'(column_index_reg) + (COL_W+1)'(1)) >= width_eff;
    assign last_row     = ((ROW_W+1)'(row_index_reg) + (ROW_W+1)'(1)) >= height_eff;
    assign block_first  = (sub_col_reg == '0) && (sub_row_reg == '0);
    assign emit_cur     = last_sub_col && last_sub_row;
    assign frame_end    = emit_cur && last_col && last_row;

    assign meta_cur.x       = COORD_W'(column_index_reg);
    assign meta_cur.y       = COORD_W'(row_index_reg);
    assign meta_cur.done    = frame_end;
    assign meta_cur.rate_m1 = RATE_CODE_W'(rate_eff - RATE_W'(1));
    assign samp_cur = {samples.sample_alpha, samples.sample_blue,
                       samples.sample_green, samples.sample_red};

    assign reserved = fifo_count + OUT_CNT_W'(s1_valid_reg && s1_emit_reg)
                    + OUT_CNT_W'(avg_valid);
    assign in_ready      = !emit_cur || (reserved < OUT_CNT_W'(OUT_DEPTH));
    assign samples.ready = in_ready;
    assign in_fire       = samples.valid && in_ready;

    always_comb
    begin
        sub_col_next      = sub_col_reg;
        column_index_next = column_index_reg;
        sub_row_next      = sub_row_reg;
        row_index_next    = row_index_reg;
        if (!last_sub_col)
        begin
            sub_col_next = sub_col_reg + SUB_W'(1);
        end
        else
        begin
            sub_col_next = '0;
            if (!last_col)
            begin
                column_index_next = column_index_reg + COL_W'(1);
            end
            else
            begin
                column_index_next = '0;
                if (!last_sub_row)
                begin
                    sub_row_next = sub_row_reg + SUB_W'(1);
                end
                else
                begin
                    sub_row_next = '0;
                    if (!last_row)
                    begin
                        row_index_next = row_index_reg + ROW_W'(1);
                    end
                    else
                    begin
                        row_index_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_cfg_reg     <= RATE_CFG_W'(RESET_RATE);
            frame_width_reg  <= DIM_CFG_W'(RESET_WIDTH);
            frame_height_reg <= DIM_CFG_W'(RESET_HEIGHT);
            sub_col_reg      <= '0;
            column_index_reg <= '0;
            sub_row_reg      <= '0;
            row_index_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s1_emit_reg      <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SS_RATE:      rate_cfg_reg     <= cfg_data[RATE_CFG_W-1:0];
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_CFG_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_CFG_W-1:0];
                    default:          ;
                endcase
            end
            if (in_fire)
            begin
                sub_col_reg      <= sub_col_next;
                column_index_reg <= column_index_next;
                sub_row_reg      <= sub_row_next;
                row_index_reg    <= row_index_next;
            end
            s1_valid_reg  <= in_fire;
            s1_emit_reg   <= in_fire && emit_cur;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg   <= column_index_reg;
            s1_first_reg <= block_first;
            s1_samp_reg  <= samp_cur;
            s1_meta_reg  <= meta_cur;
        end
        if (s1_valid_reg)
        begin
            fwd_col_reg  <= s1_col_reg;
            fwd_sums_reg <= s1_new_sums;
        end
    end

    sbr_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (SUMS_W)
    ) u_line_store (
        .clk   (clk),
        .re    (in_fire),
        .raddr (column_index_reg),
        .rdata (rd_sums),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_new_sums)
    );

    assign s1_base_sums = (fwd_valid_reg && (fwd_col_reg == s1_col_reg)) ? fwd_sums_reg
                                                                         : rd_sums;

    always_comb
    begin
        logic [SUM_W-1:0] samp;
        samp = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            samp = SUM_W'(s1_samp_reg[c*CHAN_W +: CHAN_W]);
            if (s1_first_reg)
            begin
                s1_new_sums[c*SUM_W +: SUM_W] = samp;
            end
            else
            begin
                s1_new_sums[c*SUM_W +: SUM_W] = s1_base_sums[c*SUM_W +: SUM_W] + samp;
            end
        end
    end

    sbr_avg #(
        .SUM_W (SUM_W)
    ) u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg && s1_emit_reg),
        .in_sums   (s1_new_sums),
        .in_meta   (s1_meta_reg),
        .out_valid (avg_valid),
        .out_pixel (avg_pixel)
    );

    sbr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (avg_valid),
        .push_data (avg_pixel),
        .count     (fifo_count),
        .pixels    (pixels)
    );

`ifndef NO_ASSERTIONS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reserved <= OUT_CNT_W'(OUT_DEPTH))
        else $error("output credit exceeds queue depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        avg_valid |-> (fifo_count < OUT_CNT_W'(OUT_DEPTH)) || (pixels.valid && pixels.ready))
        else $error("pixel pushed into a full output queue");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && frame_end) |=> (column_index_reg == '0) && (row_index_reg == '0)
            && (sub_col_reg == '0) && (sub_row_reg == '0))
        else $error("counters did not return to origin after frame end");
`endif

endmodule
